### design/dpd_pkg.sv
// dpd_pkg: shared constants, register codes and types for the dual pd drive controller
// no dependencies; used by dual_pd_drive_controller_unit and dpd_pd_term
package dpd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int OUT_FRAC       = 14;
  localparam int RSH = (GAIN_FRAC_BITS >= OUT_FRAC) ? (GAIN_FRAC_BITS - OUT_FRAC) : 0;
  localparam int LSH = (GAIN_FRAC_BITS <  OUT_FRAC) ? (OUT_FRAC - GAIN_FRAC_BITS) : 0;

  localparam int GOAL_W  = 16;
  localparam int GAIN_W  = 24;
  localparam int DRIVE_W = 16;
  localparam int MAG_W   = 14;   // holds 0..8192
  localparam int CORR_W  = 15;   // signed -8192..8192

  localparam int HALF_Q14 = 8192;
  localparam int TOL      = 10;

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_GOAL_DIST = 3'd0;
  localparam logic [2:0] REG_GOAL_ANG  = 3'd1;
  localparam logic [2:0] REG_ANG_KP    = 3'd2;
  localparam logic [2:0] REG_ANG_KD    = 3'd3;
  localparam logic [2:0] REG_DIST_KP   = 3'd4;
  localparam logic [2:0] REG_DIST_KD   = 3'd5;

  localparam logic [GAIN_W-1:0] ANG_KP_RST  = 24'd1507;
  localparam logic [GAIN_W-1:0] ANG_KD_RST  = 24'd0;
  localparam logic [GAIN_W-1:0] DIST_KP_RST = 24'd655;
  localparam logic [GAIN_W-1:0] DIST_KD_RST = 24'd32768;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
  } gain_pair_t;

endpackage

### design/dpd_in_if.sv
// dpd_in_if: request channel carrying encoder counts and the function code
// depends on nothing; width follows COUNT_BITS
interface dpd_in_if #(parameter int COUNT_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;

  modport source (output valid, output func, output left_count, output right_count,
                  input ready);
  modport sink   (input valid, input func, input left_count, input right_count,
                  output ready);
endinterface

### design/dpd_out_if.sv
// dpd_out_if: result channel carrying the two motor commands and the done flag
// depends on nothing
interface dpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;
  logic               done_res;

  modport source (output valid, output left_drive, output right_drive, output done_res,
                  input ready);
  modport sink   (input valid, input left_drive, input right_drive, input done_res,
                  output ready);
endinterface

### design/dual_pd_drive_controller_unit.sv
// Differential-drive PD controller with separate angle and distance loops.
// Requests arrive on in_ch (valid/ready): func selects a control tick or a clear,
// left_count/right_count are the signed encoder counts. Every request yields exactly
// one result on out_ch: left_drive, right_drive (Q2.14, within +-1.0) and done_res.
// A clear zeroes the previous errors and the sticky done flag and returns zero drives.
// Goals and gains sit behind an APB-style port (psel/penable/pwrite/paddr/pwdata/
// prdata/pready), register i at byte address 4*i; pready is tied high and writes land
// on the access cycle. Write them only while no request is in flight.
// A request accepted on in_ch is registered in stage 1 and then in the output register,
// which drives out_ch. One request per cycle while out_ch is not stalled; stage 1 forms the
// errors and updates the error history, stage 2 holds the four gain multipliers, the
// clamps and the drive mixing, and the output register holds the result.
// When out_ch stalls, the result holds and the pipe fills; in_ch.ready drops only once
// both the output register and stage 1 hold items. Synchronous active-low reset clears
// valid flags, error history and done flag, and loads the default goals and gains.
module dual_pd_drive_controller_unit #(
  parameter int COUNT_BITS = dpd_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  dpd_in_if.sink                       in_ch,
  dpd_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpd_pkg::APB_AW-1:0]   paddr,
  input  logic [dpd_pkg::APB_DW-1:0]   pwdata,
  output logic [dpd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int GW    = dpd_pkg::GAIN_W;
  localparam int GLW   = dpd_pkg::GOAL_W;
  localparam int ERR_W = ((COUNT_BITS > GLW) ? COUNT_BITS : GLW) + 2;
  localparam int DW    = dpd_pkg::DRIVE_W;

  // configuration registers
  logic signed [GLW-1:0] goal_dist_r;
  logic signed [GLW-1:0] goal_ang_r;
  logic [GW-1:0]         ang_kp_r;
  logic [GW-1:0]         ang_kd_r;
  logic [GW-1:0]         dist_kp_r;
  logic [GW-1:0]         dist_kd_r;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_dist_r <= '0;
      goal_ang_r  <= '0;
      ang_kp_r    <= dpd_pkg::ANG_KP_RST;
      ang_kd_r    <= dpd_pkg::ANG_KD_RST;
      dist_kp_r   <= dpd_pkg::DIST_KP_RST;
      dist_kd_r   <= dpd_pkg::DIST_KD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        dpd_pkg::REG_GOAL_DIST: goal_dist_r <= $signed(pwdata[GLW-1:0]);
        dpd_pkg::REG_GOAL_ANG:  goal_ang_r  <= $signed(pwdata[GLW-1:0]);
        dpd_pkg::REG_ANG_KP:    ang_kp_r    <= pwdata[GW-1:0];
        dpd_pkg::REG_ANG_KD:    ang_kd_r    <= pwdata[GW-1:0];
        dpd_pkg::REG_DIST_KP:   dist_kp_r   <= pwdata[GW-1:0];
        dpd_pkg::REG_DIST_KD:   dist_kd_r   <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      dpd_pkg::REG_GOAL_DIST: prdata = dpd_pkg::APB_DW'($unsigned(goal_dist_r));
      dpd_pkg::REG_GOAL_ANG:  prdata = dpd_pkg::APB_DW'($unsigned(goal_ang_r));
      dpd_pkg::REG_ANG_KP:    prdata = dpd_pkg::APB_DW'(ang_kp_r);
      dpd_pkg::REG_ANG_KD:    prdata = dpd_pkg::APB_DW'(ang_kd_r);
      dpd_pkg::REG_DIST_KP:   prdata = dpd_pkg::APB_DW'(dist_kp_r);
      dpd_pkg::REG_DIST_KD:   prdata = dpd_pkg::APB_DW'(dist_kd_r);
      default:                prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic adv_out;
  logic in_acc;

  assign adv_out     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv_out;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // stage 1: errors and history
  logic signed [ERR_W-1:0] l_e;
  logic signed [ERR_W-1:0] r_e;
  logic signed [ERR_W-1:0] sum_lr;
  logic signed [ERR_W-1:0] sum_adj;
  logic signed [ERR_W-1:0] half_lr;
  logic signed [ERR_W-1:0] ae;
  logic signed [ERR_W-1:0] de;
  logic signed [ERR_W:0]   ad;
  logic signed [ERR_W:0]   dd;
  logic                    in_tol;
  logic signed [ERR_W-1:0] tol_hi;
  logic signed [ERR_W-1:0] tol_lo;

  logic signed [ERR_W-1:0] prev_ae_r, prev_ae_nxt;
  logic signed [ERR_W-1:0] prev_de_r, prev_de_nxt;
  logic                    done_r, done_nxt;

  logic                    s1_clear_r;
  logic                    s1_done_r;
  logic signed [ERR_W-1:0] s1_ae_r;
  logic signed [ERR_W-1:0] s1_de_r;
  logic signed [ERR_W:0]   s1_ad_r;
  logic signed [ERR_W:0]   s1_dd_r;

  assign l_e     = ERR_W'(in_ch.left_count);
  assign r_e     = ERR_W'(in_ch.right_count);
  assign sum_lr  = l_e + r_e;
  // add one to negative sums so the halving truncates toward zero
  assign sum_adj = sum_lr + $signed({{(ERR_W-1){1'b0}}, sum_lr[ERR_W-1]});
  assign half_lr = sum_adj >>> 1;
  assign ae      = ERR_W'(goal_ang_r) + r_e - l_e;
  assign de      = ERR_W'(goal_dist_r) - half_lr;
  assign ad      = (ERR_W+1)'(ae) - (ERR_W+1)'(prev_ae_r);
  assign dd      = (ERR_W+1)'(de) - (ERR_W+1)'(prev_de_r);
  assign tol_hi  = ERR_W'(dpd_pkg::TOL);
  assign tol_lo  = -tol_hi;
  assign in_tol  = (ae <= tol_hi) && (ae >= tol_lo) && (de <= tol_hi) && (de >= tol_lo);

  always_comb begin
    prev_ae_nxt = prev_ae_r;
    prev_de_nxt = prev_de_r;
    done_nxt    = done_r;
    if (in_acc) begin
      if (in_ch.func == dpd_pkg::FUNC_CLEAR) begin
        prev_ae_nxt = '0;
        prev_de_nxt = '0;
        done_nxt    = 1'b0;
      end else begin
        prev_ae_nxt = ae;
        prev_de_nxt = de;
        done_nxt    = done_r | in_tol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ae_r  <= '0;
      prev_de_r  <= '0;
      done_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      prev_ae_r <= prev_ae_nxt;
      prev_de_r <= prev_de_nxt;
      done_r    <= done_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv_out) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_clear_r <= (in_ch.func == dpd_pkg::FUNC_CLEAR);
      s1_done_r  <= done_nxt;
      s1_ae_r    <= ae;
      s1_de_r    <= de;
      s1_ad_r    <= ad;
      s1_dd_r    <= dd;
    end
  end

  // stage 2: pd terms and drive mixing
  dpd_pkg::gain_pair_t ang_gains;
  dpd_pkg::gain_pair_t dist_gains;
  logic signed [dpd_pkg::CORR_W-1:0] ang_corr;
  logic signed [dpd_pkg::CORR_W-1:0] dist_corr;
  logic signed [DW-1:0] left_nxt;
  logic signed [DW-1:0] right_nxt;
  logic                 out_done_nxt;

  assign ang_gains  = '{kp: ang_kp_r,  kd: ang_kd_r};
  assign dist_gains = '{kp: dist_kp_r, kd: dist_kd_r};

  dpd_pd_term #(.ERR_W(ERR_W)) u_ang_term (
    .gains (ang_gains),
    .err   (s1_ae_r),
    .diff  (s1_ad_r),
    .corr  (ang_corr)
  );

  dpd_pd_term #(.ERR_W(ERR_W)) u_dist_term (
    .gains (dist_gains),
    .err   (s1_de_r),
    .diff  (s1_dd_r),
    .corr  (dist_corr)
  );

  always_comb begin
    if (s1_clear_r) begin
      left_nxt     = '0;
      right_nxt    = '0;
      out_done_nxt = 1'b0;
    end else begin
      left_nxt     = DW'(dist_corr) + DW'(ang_corr);
      right_nxt    = DW'(dist_corr) - DW'(ang_corr);
      out_done_nxt = s1_done_r;
    end
  end

  logic signed [DW-1:0] out_left_r;
  logic signed [DW-1:0] out_right_r;
  logic                 out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_drive  = out_left_r;
  assign out_ch.right_drive = out_right_r;
  assign out_ch.done_res    = out_done_r;

endmodule

### design/dpd_pd_term.sv
// dpd_pd_term: one pd correction, kp*e + kd*(e - e_prev), cut to q2.14 and clamped to +-0.5
// depends on dpd_pkg
module dpd_pd_term #(
  parameter int ERR_W = 18
) (
  input  dpd_pkg::gain_pair_t                gains,
  input  logic signed [ERR_W-1:0]            err,
  input  logic signed [ERR_W:0]              diff,
  output logic signed [dpd_pkg::CORR_W-1:0]  corr
);

  localparam int GW    = dpd_pkg::GAIN_W;
  localparam int PP_W  = GW + 1 + ERR_W;
  localparam int PD_W  = GW + 2 + ERR_W;
  localparam int SUM_W = PD_W + 1;
  localparam int MW    = dpd_pkg::MAG_W;
  localparam int SH_W  = MW + dpd_pkg::LSH;

  logic signed [GW:0]       kp_s;
  logic signed [GW:0]       kd_s;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [SUM_W-1:0]  sum;
  logic                     neg;
  logic        [SUM_W-1:0]  mag;
  logic        [SUM_W-1:0]  shifted;
  logic        [MW-1:0]     c1;
  logic        [SH_W-1:0]   c1w;
  logic        [MW-1:0]     c2;
  logic signed [dpd_pkg::CORR_W-1:0] pos;

  assign kp_s   = $signed({1'b0, gains.kp});
  assign kd_s   = $signed({1'b0, gains.kd});
  assign prod_p = kp_s * err;
  assign prod_d = kd_s * diff;
  assign sum    = SUM_W'(prod_p) + SUM_W'(prod_d);

  // sign-magnitude so the shift truncates toward zero
  assign neg     = sum[SUM_W-1];
  assign mag     = neg ? $unsigned(-sum) : $unsigned(sum);
  assign shifted = mag >> dpd_pkg::RSH;
  assign c1      = (shifted > SUM_W'(dpd_pkg::HALF_Q14)) ? MW'(dpd_pkg::HALF_Q14)
                                                         : shifted[MW-1:0];
  // scale up exactly when the gains carry fewer fraction bits than q2.14
  assign c1w     = SH_W'(c1) << dpd_pkg::LSH;
  assign c2      = (c1w > SH_W'(dpd_pkg::HALF_Q14)) ? MW'(dpd_pkg::HALF_Q14)
                                                    : c1w[MW-1:0];
  assign pos     = $signed({1'b0, c2});
  assign corr    = neg ? -pos : pos;

endmodule

### design/dpd_checker.sv
// dpd_checker: port-level checks on the result channel of the pd drive controller
// depends on dual_pd_drive_controller_unit, attached by the bind at the end of this file
module dpd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] left_drive,
  input logic signed [15:0] right_drive,
  input logic               done_res
);

  localparam logic signed [15:0] DRV_MAX = 16'sd16384;
  localparam logic signed [15:0] DRV_MIN = -16'sd16384;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_drive) &&
      $stable(right_drive) && $stable(done_res))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // each drive is the sum of two corrections clamped to half scale
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> left_drive <= DRV_MAX && left_drive >= DRV_MIN &&
      right_drive <= DRV_MAX && right_drive >= DRV_MIN)
    else $error("drive outside full scale");

  // left + right = 2 * distance correction, so the sum is even
  a_drive_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (left_drive[0] == right_drive[0]))
    else $error("drives do not share a distance term");

endmodule

bind dual_pd_drive_controller_unit dpd_checker u_dpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_drive  (out_ch.left_drive),
  .right_drive (out_ch.right_drive),
  .done_res    (out_ch.done_res)
);
